// ===== rtl/crcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcpr_pkg: shared types and constants of the packet receiver
// Holds the phase and status codes, the result record and the CRC byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package crcpr_pkg;

	localparam logic [7:0]  START_BYTE = 8'hAA;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam int          TOTAL_W    = 25;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HDR  = 2'd1,
		PH_DATA = 2'd2,
		PH_CRC  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_START_TO  = 3'd1,
		ST_HDR_SHORT = 3'd2,
		ST_BAD_LEN   = 3'd3,
		ST_DATA_SHRT = 3'd4,
		ST_CRC_ERR   = 3'd5,
		ST_SEQ_ERR   = 3'd6
	} status_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic {
		OP_BYTE    = 1'b0,
		OP_TIMEOUT = 1'b1
	} op_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  data_byte;
		status_t     status;
		logic [15:0] packet_seq;
		logic [15:0] packet_len;
		logic [15:0] crc_local;
		logic [15:0] crc_frame;
		logic        transfer_done;
		logic        transfer_failed;
	} result_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/crcpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// crcpr_ctrl: frame parser state and result generation
// Holds the parser state and forms the result of the item in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpr_ctrl #(
	parameter int MAX_PAYLOAD  = 1024,
	parameter int MAX_ATTEMPTS = 3
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         fire,
	input  wire logic                         op,
	input  wire logic [7:0]                   rx_byte,
	input  wire logic [crcpr_pkg::TOTAL_W-1:0] byte_target,
	output crcpr_pkg::result_t                res
);

	localparam int IDX_RAW = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W   = (IDX_RAW > 2) ? IDX_RAW : 2;
	localparam int ATT_W   = $clog2(MAX_ATTEMPTS + 1);
	localparam logic [15:0]   MAX_LEN = 16'(MAX_PAYLOAD);
	localparam logic [ATT_W-1:0] MAX_ATT = ATT_W'(MAX_ATTEMPTS);

	crcpr_pkg::phase_t              phase_q, phase_n;
	logic [IDX_W-1:0]               idx_q, idx_n, idx_inc;
	logic [15:0]                    seq_q, seq_n;
	logic [15:0]                    len_q, len_n;
	logic [15:0]                    crc_q, crc_n, crc_step;
	logic [7:0]                     low_q, low_n;
	logic [15:0]                    exp_q, exp_n;
	logic [crcpr_pkg::TOTAL_W-1:0]  rcvd_q, rcvd_n, rcvd_sum;
	logic [ATT_W-1:0]               att_q, att_n, att_inc;
	logic                           done_q, done_n;
	logic                           failed_q, failed_n;
	logic [15:0]                    recv_crc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= crcpr_pkg::PH_HUNT;
			idx_q    <= '0;
			seq_q    <= '0;
			len_q    <= '0;
			crc_q    <= crcpr_pkg::CRC_INIT;
			low_q    <= '0;
			exp_q    <= '0;
			rcvd_q   <= '0;
			att_q    <= '0;
			done_q   <= 1'b0;
			failed_q <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			seq_q    <= seq_n;
			len_q    <= len_n;
			crc_q    <= crc_n;
			low_q    <= low_n;
			exp_q    <= exp_n;
			rcvd_q   <= rcvd_n;
			att_q    <= att_n;
			done_q   <= done_n;
			failed_q <= failed_n;
		end
	end

	assign crc_step = crcpr_pkg::crc16_byte(crc_q, rx_byte);
	assign idx_inc  = idx_q + IDX_W'(1);
	assign att_inc  = att_q + ATT_W'(1);
	assign recv_crc = {rx_byte, low_q};
	assign rcvd_sum = rcvd_q + {{(crcpr_pkg::TOTAL_W-16){1'b0}}, len_q};

	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		seq_n    = seq_q;
		len_n    = len_q;
		crc_n    = crc_q;
		low_n    = low_q;
		exp_n    = exp_q;
		rcvd_n   = rcvd_q;
		att_n    = att_q;
		done_n   = done_q;
		failed_n = failed_q;

		res            = '0;
		res.kind       = crcpr_pkg::KIND_STATUS;
		res.status     = crcpr_pkg::ST_OK;

		if (!done_q && !failed_q) begin
			if (op == crcpr_pkg::OP_TIMEOUT) begin
				res.valid = 1'b1;
				unique case (phase_q)
					crcpr_pkg::PH_HUNT: res.status = crcpr_pkg::ST_START_TO;
					crcpr_pkg::PH_HDR:  res.status = crcpr_pkg::ST_HDR_SHORT;
					crcpr_pkg::PH_DATA,
					crcpr_pkg::PH_CRC: begin
						res.status     = crcpr_pkg::ST_DATA_SHRT;
						res.packet_seq = seq_q;
						res.packet_len = len_q;
					end
					default: res.status = crcpr_pkg::ST_START_TO;
				endcase
			end else begin
				unique case (phase_q)
					crcpr_pkg::PH_HUNT: begin
						if (rx_byte == crcpr_pkg::START_BYTE) begin
							phase_n = crcpr_pkg::PH_HDR;
							idx_n   = '0;
							crc_n   = crcpr_pkg::CRC_INIT;
							seq_n   = '0;
							len_n   = '0;
						end
					end
					crcpr_pkg::PH_HDR: begin
						crc_n = crc_step;
						idx_n = idx_inc;
						unique case (idx_q[1:0])
							2'd0:    seq_n = {8'h00, rx_byte};
							2'd1:    seq_n = {rx_byte, seq_q[7:0]};
							2'd2:    len_n = {8'h00, rx_byte};
							default: len_n = {rx_byte, len_q[7:0]};
						endcase
						if (idx_q[1:0] == 2'd3) begin
							idx_n = '0;
							if (len_n == 16'd0 || len_n > MAX_LEN) begin
								res.valid      = 1'b1;
								res.status     = crcpr_pkg::ST_BAD_LEN;
								res.packet_seq = seq_n;
								res.packet_len = len_n;
							end else begin
								phase_n = crcpr_pkg::PH_DATA;
							end
						end
					end
					crcpr_pkg::PH_DATA: begin
						crc_n = crc_step;
						idx_n = idx_inc;
						if ({{(16-IDX_W){1'b0}}, idx_inc} >= len_q) begin
							phase_n = crcpr_pkg::PH_CRC;
							idx_n   = '0;
						end
						res.valid      = 1'b1;
						res.kind       = crcpr_pkg::KIND_DATA;
						res.data_byte  = rx_byte;
						res.packet_seq = seq_q;
						res.packet_len = len_q;
					end
					crcpr_pkg::PH_CRC: begin
						if (idx_q == '0) begin
							low_n = rx_byte;
							idx_n = IDX_W'(1);
						end else begin
							res.valid      = 1'b1;
							res.packet_seq = seq_q;
							res.packet_len = len_q;
							res.crc_local  = crc_q;
							res.crc_frame  = recv_crc;
							if (crc_q != recv_crc) begin
								res.status = crcpr_pkg::ST_CRC_ERR;
							end else if (seq_q != exp_q) begin
								res.status = crcpr_pkg::ST_SEQ_ERR;
							end else begin
								res.status = crcpr_pkg::ST_OK;
								rcvd_n     = rcvd_sum;
								exp_n      = exp_q + 16'd1;
								att_n      = '0;
								phase_n    = crcpr_pkg::PH_HUNT;
								idx_n      = '0;
								if (rcvd_sum >= byte_target) begin
									done_n = 1'b1;
								end
							end
						end
					end
					default: phase_n = crcpr_pkg::PH_HUNT;
				endcase
			end

			if (res.valid && res.kind == crcpr_pkg::KIND_STATUS &&
			    res.status != crcpr_pkg::ST_OK) begin
				att_n   = att_inc;
				phase_n = crcpr_pkg::PH_HUNT;
				idx_n   = '0;
				if (att_inc >= MAX_ATT) begin
					failed_n = 1'b1;
				end
			end
		end

		res.transfer_done   = done_n;
		res.transfer_failed = failed_n;
	end

endmodule

`default_nettype wire

// ===== rtl/crc16_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// crc16_packet_receiver: framed byte-stream receiver with CRC-16/MODBUS check
// Input register, parser state with result forming, and an output register.
// ----------------------------------------------------------------------------
// An accepted input beat is captured in the input register; its result is then
// registered in the output register. Throughput: one beat per cycle; the input
// stage advances whenever the output register is empty or is being read in the same cycle.
// Reset: arst_n clears all control state, sets the stored byte target to 1 and starts the
// parser hunting for the start byte. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_packet_receiver #(
	parameter int MAX_PAYLOAD  = 1024,
	parameter int MAX_ATTEMPTS = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [crcpr_pkg::TOTAL_W-1:0] byte_target,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          operation,
	input  wire logic [7:0]                    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               kind,
	output logic [7:0]                         data_byte,
	output logic [2:0]                         status,
	output logic [15:0]                        packet_seq,
	output logic [15:0]                        packet_len,
	output logic [15:0]                        crc_local,
	output logic [15:0]                        crc_frame,
	output logic                               transfer_done,
	output logic                               transfer_failed
);

	logic [crcpr_pkg::TOTAL_W-1:0] total_q;
	logic                          valid_s1;
	logic                          op_s1;
	logic [7:0]                    byte_s1;
	logic                          advance;
	crcpr_pkg::result_t            res;
	crcpr_pkg::result_t            res_s2;

	assign cfg_ready = 1'b1;
	assign advance   = !res_s2.valid || out_ready;
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= crcpr_pkg::TOTAL_W'(1);
		end else if (cfg_valid) begin
			total_q <= byte_target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
	end

	crcpr_ctrl #(
		.MAX_PAYLOAD  (MAX_PAYLOAD),
		.MAX_ATTEMPTS (MAX_ATTEMPTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (valid_s1 && advance),
		.op          (op_s1),
		.rx_byte     (byte_s1),
		.byte_target (total_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (advance) begin
			res_s2 <= valid_s1 ? res : '0;
		end
	end

	assign out_valid       = res_s2.valid;
	assign kind            = res_s2.kind;
	assign data_byte       = res_s2.data_byte;
	assign status          = res_s2.status;
	assign packet_seq      = res_s2.packet_seq;
	assign packet_len      = res_s2.packet_len;
	assign crc_local       = res_s2.crc_local;
	assign crc_frame       = res_s2.crc_frame;
	assign transfer_done   = res_s2.transfer_done;
	assign transfer_failed = res_s2.transfer_failed;

endmodule

`default_nettype wire
